// File: sv/sbda_pkg.sv
package sbda_pkg;

  localparam logic [6:0] CHAR_MINUS = 7'd45;
  localparam logic [6:0] CHAR_ZERO  = 7'd48;

  typedef enum logic [1:0] {
    E_IDLE,
    E_SIGN,
    E_SKIP,
    E_DIGIT
  } emit_state_t;

  // Double-dabble correction: add three to a BCD digit of five or more.
  function automatic logic [3:0] bcd_adjust(input logic [3:0] d);
    logic [3:0] r;
    r = (d >= 4'd5) ? d + 4'd3 : d;
    return r;
  endfunction

endpackage

// File: sv/sbda_conv.sv
module sbda_conv
  import sbda_pkg::*;
#(
  parameter int W  = 32,
  parameter int ND = 10
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [W-1:0]    mag_in,
  input  logic            neg_in,
  output logic            idle,
  output logic            res_valid,
  output logic [4*ND-1:0] res_bcd,
  output logic            res_neg,
  input  logic            res_take
);

  localparam int BW = $clog2(W + 1);

  logic            busy;
  logic            full;
  logic [W-1:0]    mag;
  logic [4*ND-1:0] bcd;
  logic [4*ND-1:0] bcd_adj;
  logic [BW-1:0]   bitcnt;
  logic            neg;

  // Correct every digit in parallel before the shift.
  always_comb begin
    for (int i = 0; i < ND; i++) begin
      bcd_adj[4*i +: 4] = bcd_adjust(bcd[4*i +: 4]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      full <= 1'b0;
    end else begin
      if (start) begin
        busy <= 1'b1;
      end else if (busy && bitcnt == BW'(1)) begin
        busy <= 1'b0;
        full <= 1'b1;
      end else if (full && res_take) begin
        full <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mag    <= mag_in;
      neg    <= neg_in;
      bcd    <= '0;
      bitcnt <= BW'(W);
    end else if (busy) begin
      bcd    <= {bcd_adj[4*ND-2:0], mag[W-1]};
      mag    <= {mag[W-2:0], 1'b0};
      bitcnt <= bitcnt - BW'(1);
    end
  end

  assign idle      = !busy && !full;
  assign res_valid = full;
  assign res_bcd   = bcd;
  assign res_neg   = neg;

endmodule

// File: sv/sbda_emit.sv
module sbda_emit
  import sbda_pkg::*;
#(
  parameter int ND = 10
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            res_valid,
  input  logic [4*ND-1:0] res_bcd,
  input  logic            res_neg,
  output logic            res_take,
  output logic            char_valid,
  input  logic            char_stall,
  output logic [6:0]      char_code,
  output logic            last
);

  localparam int CW = $clog2(ND + 1);

  emit_state_t     state;
  emit_state_t     state_next;
  logic [4*ND-1:0] sreg;
  logic [4*ND-1:0] sreg_next;
  logic [CW-1:0]   cnt;
  logic [CW-1:0]   cnt_next;
  logic            ovalid;
  logic [6:0]      ochar;
  logic            olast;
  logic            emit;
  logic [6:0]      emit_char;
  logic            emit_last;
  logic            out_free;
  logic [3:0]      top;

  assign out_free = !ovalid || !char_stall;
  assign top      = sreg[4*ND-1 -: 4];

  always_comb begin
    state_next = state;
    sreg_next  = sreg;
    cnt_next   = cnt;
    res_take   = 1'b0;
    emit       = 1'b0;
    emit_char  = CHAR_ZERO + {3'b000, top};
    emit_last  = (cnt == CW'(1));
    case (state)
      E_IDLE: begin
        if (res_valid) begin
          res_take   = 1'b1;
          sreg_next  = res_bcd;
          cnt_next   = CW'(ND);
          state_next = res_neg ? E_SIGN : E_SKIP;
        end
      end
      E_SIGN: begin
        if (out_free) begin
          emit       = 1'b1;
          emit_char  = CHAR_MINUS;
          emit_last  = 1'b0;
          state_next = E_SKIP;
        end
      end
      E_SKIP, E_DIGIT: begin
        if (state == E_SKIP && top == 4'd0 && cnt != CW'(1)) begin
          // drop a leading zero
          sreg_next = {sreg[4*ND-5:0], 4'b0000};
          cnt_next  = cnt - CW'(1);
        end else if (out_free) begin
          emit       = 1'b1;
          sreg_next  = {sreg[4*ND-5:0], 4'b0000};
          cnt_next   = cnt - CW'(1);
          state_next = (cnt == CW'(1)) ? E_IDLE : E_DIGIT;
        end
      end
      default: begin
        state_next = E_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= E_IDLE;
      ovalid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_free) begin
        ovalid <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    sreg <= sreg_next;
    cnt  <= cnt_next;
    if (out_free && emit) begin
      ochar <= emit_char;
      olast <= emit_last;
    end
  end

  assign char_valid = ovalid;
  assign char_code  = ochar;
  assign last       = olast;

endmodule

// File: sv/signed_binary_to_decimal_ascii.sv
// Channel  Direction  Handshake                 Payload
// value    input      value_valid / value_stall value (signed, VALUE_WIDTH bits)
// char     output     char_valid / char_stall   char_code (7 bits), last
//
// A word is converted by a shift-and-add-3 loop, one magnitude bit per cycle;
// the digits are then held for the emitter, and the loop accepts the next
// word once the emitter has taken them.
// The emitter takes the digits, sends a minus sign for a negative word, then
// visits each decimal digit position in turn (suppressed or sent); the next
// word converts meanwhile.
// Reset clears the loop and emitter control; stalls on char hold the output
// register and the emitter, and back up into value_stall once a result waits.
module signed_binary_to_decimal_ascii
  import sbda_pkg::*;
#(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          value_valid,
  output logic                          value_stall,
  input  logic signed [VALUE_WIDTH-1:0] value,
  output logic                          char_valid,
  input  logic                          char_stall,
  output logic [6:0]                    char_code,
  output logic                          last
);

  // Decimal digits needed for the magnitude 2^(VALUE_WIDTH-1).
  localparam int NUM_DIGITS = ((VALUE_WIDTH - 1) * 30103) / 100000 + 1;

  logic                    conv_idle;
  logic                    start;
  logic                    neg;
  logic [VALUE_WIDTH-1:0]  mag;
  logic                    res_valid;
  logic [4*NUM_DIGITS-1:0] res_bcd;
  logic                    res_neg;
  logic                    res_take;

  assign value_stall = !conv_idle;
  assign start       = value_valid && conv_idle;

  // Take the magnitude in VALUE_WIDTH unsigned bits so the most negative
  // value converts without overflow.
  assign neg = value[VALUE_WIDTH-1];
  assign mag = neg ? (~unsigned'(value) + {{(VALUE_WIDTH-1){1'b0}}, 1'b1})
                   : unsigned'(value);

  sbda_conv #(
    .W  (VALUE_WIDTH),
    .ND (NUM_DIGITS)
  ) u_conv (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .mag_in    (mag),
    .neg_in    (neg),
    .idle      (conv_idle),
    .res_valid (res_valid),
    .res_bcd   (res_bcd),
    .res_neg   (res_neg),
    .res_take  (res_take)
  );

  sbda_emit #(
    .ND (NUM_DIGITS)
  ) u_emit (
    .clk        (clk),
    .rst        (rst),
    .res_valid  (res_valid),
    .res_bcd    (res_bcd),
    .res_neg    (res_neg),
    .res_take   (res_take),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_code  (char_code),
    .last       (last)
  );

  // A minus sign never ends a word's text.
  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    (char_valid && char_code == CHAR_MINUS) |-> !last)
    else $error("minus sign flagged as last");

  // Every character is a minus sign or a decimal digit.
  a_char_legal: assert property (@(posedge clk) disable iff (rst)
    char_valid |-> (char_code == CHAR_MINUS ||
                    (char_code >= CHAR_ZERO && char_code <= CHAR_ZERO + 7'd9)))
    else $error("illegal character code");

  // An accepted word keeps the converter busy on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (value_valid && !value_stall) |=> value_stall)
    else $error("converter idle right after accepting a word");

endmodule
